// ===== rtl/tbo_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Trim button offset controller package
// Beat types, register indexes, phase codes and beep pattern counts.
// ----------------------------------------------------------------------------
package tbo_pkg;

  localparam int unsigned CFG_IDX_W  = 3;
  localparam int unsigned CFG_DATA_W = 16;

  localparam logic [CFG_IDX_W-1:0] REG_DEBOUNCE  = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_TRIM_STEP = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_ROLL_REF  = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_PITCH_REF = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_YAW_REF   = 3'd4;

  localparam logic [1:0] PH_DEBOUNCE = 2'd0;
  localparam logic [1:0] PH_ARMED    = 2'd1;
  localparam logic [1:0] PH_PRESS    = 2'd2;

  // Key bit positions; a key reads 0 while pressed.
  localparam int unsigned KEY_YAW_UP     = 0;
  localparam int unsigned KEY_PITCH_DOWN = 1;
  localparam int unsigned KEY_ROLL_UP    = 2;
  localparam int unsigned KEY_PITCH_UP   = 3;
  localparam int unsigned KEY_ROLL_DOWN  = 4;
  localparam int unsigned KEY_YAW_DOWN   = 5;

  localparam logic [5:0] PAT_ON_A   = 6'd1;
  localparam logic [5:0] PAT_OFF_A  = 6'd10;
  localparam logic [5:0] PAT_ON_B   = 6'd20;
  localparam logic [5:0] PAT_OFF_B  = 6'd30;
  localparam logic [5:0] PAT_ON_C   = 6'd40;
  localparam logic [5:0] PAT_OFF_C  = 6'd50;
  localparam logic [5:0] PAT_LEN    = 6'd60;

  localparam logic [15:0] DEBOUNCE_RST  = 16'd10;
  localparam logic [9:0]  TRIM_STEP_RST = 10'd10;

  typedef struct packed {
    logic [5:0]  key_levels;
    logic [31:0] now_ticks;
  } in_beat_t;

  typedef struct packed {
    logic               beeper_on;
    logic               led_on;
    logic signed [15:0] roll_trim;
    logic signed [15:0] pitch_trim;
    logic signed [15:0] yaw_trim;
    logic               reference_hit;
  } out_beat_t;

  typedef struct packed {
    logic [15:0]        debounce_ticks;
    logic [9:0]         trim_step;
    logic signed [15:0] roll_reference;
    logic signed [15:0] pitch_reference;
    logic signed [15:0] yaw_reference;
  } cfg_t;

  typedef struct packed {
    logic [1:0]         phase;
    logic [31:0]        last_press_time;
    logic               pattern_active;
    logic [5:0]         pattern_count;
    logic signed [15:0] roll_offset;
    logic signed [15:0] pitch_offset;
    logic signed [15:0] yaw_offset;
    logic               beeper_level;
    logic               led_level;
  } state_t;

endpackage

// ===== rtl/tbo_step.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Trim button offset controller poll step
// Computes the next controller state and the result beat for one poll.
// ----------------------------------------------------------------------------
module tbo_step (
  input  tbo_pkg::state_t    cur,
  input  tbo_pkg::cfg_t      cfg,
  input  tbo_pkg::in_beat_t  beat,
  output tbo_pkg::state_t    nxt,
  output tbo_pkg::out_beat_t res
);

  logic [5:0]  pressed;
  logic [31:0] elapsed;
  logic [15:0] step16;
  logic [15:0] roll_up;
  logic [15:0] roll_dn;
  logic [15:0] pitch_up;
  logic [15:0] pitch_dn;
  logic [15:0] yaw_up;
  logic [15:0] yaw_dn;
  logic [5:0]  cnt;
  logic        hit;

  assign pressed  = ~beat.key_levels;
  assign elapsed  = beat.now_ticks - cur.last_press_time;
  assign step16   = {6'd0, cfg.trim_step};
  assign roll_up  = cur.roll_offset + step16;
  assign roll_dn  = cur.roll_offset - step16;
  assign pitch_up = cur.pitch_offset + step16;
  assign pitch_dn = cur.pitch_offset - step16;
  assign yaw_up   = cur.yaw_offset + step16;
  assign yaw_dn   = cur.yaw_offset - step16;
  assign cnt      = cur.pattern_count + 6'd1;

  always_comb begin
    tbo_pkg::state_t s;
    s   = cur;
    hit = 1'b0;
    unique case (cur.phase)
      tbo_pkg::PH_DEBOUNCE: begin
        if (elapsed > {16'd0, cfg.debounce_ticks}) begin
          if (pressed == 6'd0) begin
            s.phase = tbo_pkg::PH_ARMED;
          end
          s.beeper_level = 1'b0;
          s.led_level    = 1'b0;
        end
      end
      tbo_pkg::PH_ARMED: begin
        if (pressed != 6'd0) begin
          s.phase = tbo_pkg::PH_PRESS;
        end
      end
      tbo_pkg::PH_PRESS: begin
        if (pressed[tbo_pkg::KEY_ROLL_DOWN]) begin
          s.roll_offset = roll_dn;
          hit = (roll_dn == cfg.roll_reference);
        end else if (pressed[tbo_pkg::KEY_ROLL_UP]) begin
          s.roll_offset = roll_up;
          hit = (roll_up == cfg.roll_reference);
        end else if (pressed[tbo_pkg::KEY_PITCH_UP]) begin
          s.pitch_offset = pitch_up;
          hit = (pitch_up == cfg.pitch_reference);
        end else if (pressed[tbo_pkg::KEY_PITCH_DOWN]) begin
          s.pitch_offset = pitch_dn;
          hit = (pitch_dn == cfg.pitch_reference);
        end else if (pressed[tbo_pkg::KEY_YAW_UP]) begin
          s.yaw_offset = yaw_up;
          hit = (yaw_up == cfg.yaw_reference);
        end else if (pressed[tbo_pkg::KEY_YAW_DOWN]) begin
          s.yaw_offset = yaw_dn;
          hit = (yaw_dn == cfg.yaw_reference);
        end
        if (hit) begin
          s.pattern_active = 1'b1;
        end
        s.phase           = tbo_pkg::PH_DEBOUNCE;
        s.beeper_level    = 1'b1;
        s.led_level       = 1'b1;
        s.last_press_time = beat.now_ticks;
      end
      default: begin
      end
    endcase

    if (s.pattern_active) begin
      s.pattern_count = cnt;
      if (cnt == tbo_pkg::PAT_ON_A || cnt == tbo_pkg::PAT_ON_B ||
          cnt == tbo_pkg::PAT_ON_C) begin
        s.beeper_level = 1'b1;
        s.led_level    = 1'b1;
      end else if ((cnt > tbo_pkg::PAT_OFF_A && cnt < tbo_pkg::PAT_ON_B) ||
                   (cnt > tbo_pkg::PAT_OFF_B && cnt < tbo_pkg::PAT_ON_C) ||
                   (cnt > tbo_pkg::PAT_OFF_C && cnt <= tbo_pkg::PAT_LEN)) begin
        s.beeper_level = 1'b0;
        s.led_level    = 1'b0;
        if (cnt == tbo_pkg::PAT_LEN) begin
          s.pattern_active = 1'b0;
          s.pattern_count  = 6'd0;
        end
      end
    end
    nxt = s;
  end

  assign res.beeper_on     = nxt.beeper_level;
  assign res.led_on        = nxt.led_level;
  assign res.roll_trim     = nxt.roll_offset;
  assign res.pitch_trim    = nxt.pitch_offset;
  assign res.yaw_trim      = nxt.yaw_offset;
  assign res.reference_hit = hit;

endmodule

// ===== rtl/trim_button_offset_controller.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Trim button offset controller
// Polls six trim keys, steps the roll, pitch and yaw trims and drives the
// beeper and LED, including a triple-beep pattern on a reference hit.
//
//   channel | ports                          | beat
//   input   | in_valid, in_stall, in_data    | one key poll with tick count
//   result  | out_valid, out_stall, out_data | levels and trims after the poll
//   config  | cfg_we, cfg_index, cfg_wdata   | one register write
//
// A poll is accepted in any cycle with the skid entry empty. Its result beat
// is registered at that edge, in the skid entry if the output is stalled.
// The whole poll step is one combinational pass into the result register.
// A two-entry output buffer lets a new poll enter while a result waits.
// in_stall rises only when both entries are full.
// Synchronous reset clears state and loads the register defaults.
// ----------------------------------------------------------------------------
module trim_button_offset_controller (
  input  logic                                    clk,
  input  logic                                    rst_n,
  input  logic                                    in_valid,
  output logic                                    in_stall,
  input  tbo_pkg::in_beat_t                       in_data,
  output logic                                    out_valid,
  input  logic                                    out_stall,
  output tbo_pkg::out_beat_t                      out_data,
  input  logic                                    cfg_we,
  input  logic [tbo_pkg::CFG_IDX_W-1:0]           cfg_index,
  input  logic [tbo_pkg::CFG_DATA_W-1:0]          cfg_wdata
);

  tbo_pkg::state_t    state_r;
  tbo_pkg::state_t    state_nxt;
  tbo_pkg::cfg_t      cfg_r;
  tbo_pkg::out_beat_t step_res;
  tbo_pkg::out_beat_t out_data_r;
  tbo_pkg::out_beat_t out_data_nxt;
  tbo_pkg::out_beat_t skid_data_r;
  tbo_pkg::out_beat_t skid_data_nxt;
  logic               out_valid_r;
  logic               out_valid_nxt;
  logic               skid_valid_r;
  logic               skid_valid_nxt;
  logic               in_acc;
  logic               out_take;

  tbo_step u_step (
    .cur  (state_r),
    .cfg  (cfg_r),
    .beat (in_data),
    .nxt  (state_nxt),
    .res  (step_res)
  );

  assign in_stall  = skid_valid_r;
  assign in_acc    = in_valid && !skid_valid_r;
  assign out_take  = out_valid_r && !out_stall;
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  always_comb begin
    out_valid_nxt  = out_valid_r;
    out_data_nxt   = out_data_r;
    skid_valid_nxt = skid_valid_r;
    skid_data_nxt  = skid_data_r;
    if (skid_valid_r) begin
      if (out_take) begin
        out_data_nxt   = skid_data_r;
        skid_valid_nxt = 1'b0;
      end
    end else if (in_acc) begin
      if (!out_valid_r || out_take) begin
        out_valid_nxt = 1'b1;
        out_data_nxt  = step_res;
      end else begin
        skid_valid_nxt = 1'b1;
        skid_data_nxt  = step_res;
      end
    end else if (out_take) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r                 <= '0;
      cfg_r.debounce_ticks    <= tbo_pkg::DEBOUNCE_RST;
      cfg_r.trim_step         <= tbo_pkg::TRIM_STEP_RST;
      cfg_r.roll_reference    <= '0;
      cfg_r.pitch_reference   <= '0;
      cfg_r.yaw_reference     <= '0;
      out_valid_r             <= 1'b0;
      skid_valid_r            <= 1'b0;
    end else begin
      if (in_acc) begin
        state_r <= state_nxt;
      end
      if (cfg_we) begin
        unique case (cfg_index)
          tbo_pkg::REG_DEBOUNCE:  cfg_r.debounce_ticks  <= cfg_wdata;
          tbo_pkg::REG_TRIM_STEP: cfg_r.trim_step       <= cfg_wdata[9:0];
          tbo_pkg::REG_ROLL_REF:  cfg_r.roll_reference  <= cfg_wdata;
          tbo_pkg::REG_PITCH_REF: cfg_r.pitch_reference <= cfg_wdata;
          tbo_pkg::REG_YAW_REF:   cfg_r.yaw_reference   <= cfg_wdata;
          default: begin
          end
        endcase
      end
      out_valid_r  <= out_valid_nxt;
      skid_valid_r <= skid_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_data_r  <= out_data_nxt;
    skid_data_r <= skid_data_nxt;
  end

  a_skid_implies_out: assert property (@(posedge clk) disable iff (!rst_n)
    skid_valid_r |-> out_valid_r)
    else $error("skid entry held without an output entry");

  a_accept_gives_result: assert property (@(posedge clk) disable iff (!rst_n)
    in_acc |=> out_valid_r)
    else $error("accepted poll produced no result beat");

  a_count_needs_pattern: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r.pattern_count != 6'd0) |-> state_r.pattern_active)
    else $error("pattern counter running with pattern inactive");

  a_press_returns: assert property (@(posedge clk) disable iff (!rst_n)
    (in_acc && state_r.phase == tbo_pkg::PH_PRESS)
      |=> state_r.phase == tbo_pkg::PH_DEBOUNCE)
    else $error("press phase did not return to debounce");

  a_hit_starts_pattern: assert property (@(posedge clk) disable iff (!rst_n)
    (in_acc && step_res.reference_hit && !state_r.pattern_active)
      |=> state_r.pattern_active)
    else $error("reference hit did not start the beep pattern");

endmodule
